FILE: design/cc20_pkg.sv
`timescale 1ns / 1ps

package cc20_pkg;

  // default number of double rounds (ten gives the standard twenty rounds)
  localparam int DOUBLE_ROUNDS_DEF = 10;

  // state geometry
  localparam int WORDS      = 16;
  localparam int WORD_IDX_W = $clog2(WORDS);
  localparam int OFF_W      = 6;

  // decoupling queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [3:0][31:0] SIGMA = {32'h6b206574, 32'h79622d32,
                                        32'h3320646e, 32'h61707865};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_0,
    REG_KEY_1,
    REG_KEY_2,
    REG_KEY_3,
    REG_NONCE_LOW,
    REG_NONCE_HIGH,
    REG_INIT_CTR
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FF,
    ST_FETCH,
    ST_DELIVER
  } core_state_e;

  typedef struct packed {
    logic [7:0][31:0] key;
    logic [2:0][31:0] nonce;
    logic [31:0]      init_ctr;
  } cfg_t;

  // one classified byte waiting for the back end
  typedef struct packed {
    logic [7:0]       data;
    logic [OFF_W-1:0] off;
    logic             need_blk;
    logic [31:0]      ctr;
  } item_t;

  // initial state word for a given index
  function automatic logic [31:0] init_word(logic [WORD_IDX_W-1:0] idx, cfg_t cfg,
                                            logic [31:0] ctr);
    logic [WORD_IDX_W-1:0] k;
    logic [WORD_IDX_W-1:0] n;
    logic [31:0]           res;
    k = idx - WORD_IDX_W'(4);
    n = idx - WORD_IDX_W'(13);
    if (idx < WORD_IDX_W'(4)) begin
      res = SIGMA[idx[1:0]];
    end else if (idx < WORD_IDX_W'(12)) begin
      res = cfg.key[k[2:0]];
    end else if (idx == WORD_IDX_W'(12)) begin
      res = ctr;
    end else begin
      res = cfg.nonce[n[1:0]];
    end
    return res;
  endfunction

  // word index of one quarter-round operand; diagonal rounds skew the lanes
  function automatic logic [WORD_IDX_W-1:0] qr_idx(logic [1:0] row, logic [1:0] lane,
                                                   logic diag);
    logic [1:0] col;
    col = lane + (diag ? row : 2'd0);
    return {row, col};
  endfunction

  // rotate left by the amount used in each quarter-round step
  function automatic logic [31:0] rot_step(logic [31:0] v, logic [1:0] step);
    logic [31:0] res;
    unique case (step)
      2'd0:    res = {v[15:0], v[31:16]};
      2'd1:    res = {v[19:0], v[31:20]};
      2'd2:    res = {v[23:0], v[31:24]};
      default: res = {v[24:0], v[31:25]};
    endcase
    return res;
  endfunction

endpackage

FILE: design/cc20_fifo.sv
`timescale 1ns / 1ps

module cc20_fifo
  import cc20_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t wdata_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t rdata_o,
  output logic  empty_o
);

  item_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

FILE: design/cc20_front.sv
`timescale 1ns / 1ps

module cc20_front
  import cc20_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic [7:0] data_in_i,
  input  logic       message_start_i,
  input  logic       push_i,
  output logic       full_o,
  input  logic       head_pop_i,
  output item_t      head_o,
  output logic       head_empty_o
);

  logic [OFF_W-1:0] off_q, off_d;
  logic [31:0]      ctr_q, ctr_d;
  logic [OFF_W-1:0] cur_off;
  logic [31:0]      cur_ctr;
  logic             accept;
  item_t            item;

  assign accept = push_i && !full_o;

  // classify: position in the block and whether a new block is due
  always_comb begin
    cur_off       = message_start_i ? '0 : off_q;
    cur_ctr       = message_start_i ? cfg_i.init_ctr : ctr_q;
    item.data     = data_in_i;
    item.off      = cur_off;
    item.need_blk = (cur_off == '0);
    item.ctr      = cur_ctr;
    off_d         = off_q;
    ctr_d         = ctr_q;
    if (accept) begin
      off_d = cur_off + 1'b1;
      ctr_d = item.need_blk ? cur_ctr + 32'd1 : cur_ctr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0;
      ctr_q <= '0;
    end else begin
      off_q <= off_d;
      ctr_q <= ctr_d;
    end
  end

  cc20_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (item),
    .full_o  (full_o),
    .pop_i   (head_pop_i),
    .rdata_o (head_o),
    .empty_o (head_empty_o)
  );

endmodule

FILE: design/cc20_core.sv
`timescale 1ns / 1ps

module cc20_core
  import cc20_pkg::*;
#(
  parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  item_t      head_i,
  input  logic       head_empty_i,
  output logic       head_pop_o,
  input  logic       out_pop_i,
  output logic       out_empty_o,
  output logic [7:0] data_out_o
);

  localparam int RND_W = $clog2(2 * DOUBLE_ROUNDS);
  localparam logic [RND_W-1:0] RND_LAST = RND_W'(2 * DOUBLE_ROUNDS - 1);

  core_state_e           state_q, state_d;
  logic [RND_W-1:0]      rnd_q, rnd_d;
  logic [1:0]            step_q, step_d;
  logic [WORD_IDX_W-1:0] ff_cnt_q, ff_cnt_d;
  logic [WORDS-1:0][31:0] w_q, w_d, w_step;
  logic [31:0]           ks_mem [WORDS];
  logic [31:0]           rd_word_q;
  logic [1:0]            sel_q;
  logic [31:0]           ff_word;
  logic [7:0]            ks_byte;
  logic                  out_valid_q;
  logic [7:0]            data_out_q;
  logic                  rd_en, ff_we, out_load;

  // one quarter-round step on all four lanes: one add, xor and rotate each
  always_comb begin
    logic [WORD_IDX_W-1:0] xi, yi, zi;
    logic [31:0]           sum;
    w_step = w_q;
    for (int i = 0; i < 4; i++) begin
      if (!step_q[0]) begin
        xi = qr_idx(2'd0, 2'(i), rnd_q[0]);
        yi = qr_idx(2'd1, 2'(i), rnd_q[0]);
        zi = qr_idx(2'd3, 2'(i), rnd_q[0]);
      end else begin
        xi = qr_idx(2'd2, 2'(i), rnd_q[0]);
        yi = qr_idx(2'd3, 2'(i), rnd_q[0]);
        zi = qr_idx(2'd1, 2'(i), rnd_q[0]);
      end
      sum        = w_q[xi] + w_q[yi];
      w_step[xi] = sum;
      w_step[zi] = rot_step(w_q[zi] ^ sum, step_q);
    end
  end

  // feed-forward of the word at the bottom of the shifting state
  assign ff_word = w_q[0] + init_word(ff_cnt_q, cfg_i, head_i.ctr);

  // sequencer: block generation, keystream read, result hand-off
  always_comb begin
    state_d    = state_q;
    rnd_d      = rnd_q;
    step_d     = step_q;
    ff_cnt_d   = ff_cnt_q;
    w_d        = w_q;
    rd_en      = 1'b0;
    ff_we      = 1'b0;
    out_load   = 1'b0;
    head_pop_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!head_empty_i) begin
          if (head_i.need_blk) begin
            for (int i = 0; i < WORDS; i++) begin
              w_d[i] = init_word(WORD_IDX_W'(i), cfg_i, head_i.ctr);
            end
            rnd_d   = '0;
            step_d  = '0;
            state_d = ST_ROUND;
          end else begin
            rd_en   = 1'b1;
            state_d = ST_DELIVER;
          end
        end
      end
      ST_ROUND: begin
        w_d    = w_step;
        step_d = step_q + 1'b1;
        if (step_q == 2'd3) begin
          rnd_d = rnd_q + 1'b1;
          if (rnd_q == RND_LAST) begin
            ff_cnt_d = '0;
            state_d  = ST_FF;
          end
        end
      end
      ST_FF: begin
        ff_we    = 1'b1;
        ff_cnt_d = ff_cnt_q + 1'b1;
        for (int i = 0; i < WORDS - 1; i++) begin
          w_d[i] = w_q[i+1];
        end
        if (ff_cnt_q == WORD_IDX_W'(WORDS - 1)) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        rd_en   = 1'b1;
        state_d = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (!out_valid_q || out_pop_i) begin
          out_load   = 1'b1;
          head_pop_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rnd_q    <= '0;
      step_q   <= '0;
      ff_cnt_q <= '0;
    end else begin
      state_q  <= state_d;
      rnd_q    <= rnd_d;
      step_q   <= step_d;
      ff_cnt_q <= ff_cnt_d;
    end
  end

  // working state
  always_ff @(posedge clk_i) begin
    w_q <= w_d;
  end

  // keystream word memory, registered read
  always_ff @(posedge clk_i) begin
    if (ff_we) begin
      ks_mem[ff_cnt_q] <= ff_word;
    end
    if (rd_en) begin
      rd_word_q <= ks_mem[head_i.off[OFF_W-1:2]];
      sel_q     <= head_i.off[1:0];
    end
  end

  // little-endian byte pick
  always_comb begin
    unique case (sel_q)
      2'd0:    ks_byte = rd_word_q[7:0];
      2'd1:    ks_byte = rd_word_q[15:8];
      2'd2:    ks_byte = rd_word_q[23:16];
      default: ks_byte = rd_word_q[31:24];
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      data_out_q <= head_i.data ^ ks_byte;
    end
  end

  assign out_empty_o = !out_valid_q;
  assign data_out_o  = data_out_q;

  // queue head is only released when present
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_pop_o |-> !head_empty_i)
    else $error("queue pop while empty");

  // a result never overwrites one that has not been transferred
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_pop_i))
    else $error("result register overrun");

  // feed-forward starts only after the last quarter step of the last round
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FF && $past(state_q) == ST_ROUND) |->
      ($past(rnd_q) == RND_LAST && $past(step_q) == 2'd3))
    else $error("feed-forward entered early");

  // delivery always follows a keystream read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DELIVER && $past(state_q) != ST_DELIVER) |-> $past(rd_en))
    else $error("delivery without keystream read");

endmodule

FILE: design/chacha20_stream_cipher.sv
`timescale 1ns / 1ps

// ChaCha20 byte-stream cipher, 32-bit block counter and 96-bit nonce.
// Input side is a queue: data_in_i and message_start_i transfer when push is
// high and full is low. Result side is a single register: data_out_o holds
// the result while empty is low and transfers when pop is high.
// message_start_i restarts the message: counter from initial_counter, offset 0.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_index_i at once
// (key words, nonce, initial counter); write only while the block is idle.
// Flow: a byte that needs no new block goes through the queue, a registered
// keystream word read and the result register; the back end finishes one
// byte before it takes the next. A byte at block offset 0 also waits for
// block generation: load of the initial state, the rounds on the shared
// quarter-round step unit, feed-forward into the keystream word memory,
// then fetch and hand-off. A two-entry queue lets the front keep taking
// bytes meanwhile.
// Reset clears the configuration, counter and offset and empties the queue and
// the result register; no clearing pass is needed.
// When the receiver stalls, the result register holds, the queue fills and
// full rises; nothing is lost.

module chacha20_stream_cipher
  import cc20_pkg::*;
#(
  parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [7:0]            data_in_i,
  input  logic                  message_start_i,
  input  logic                  push,
  output logic                  full,
  output logic [7:0]            data_out_o,
  output logic                  empty,
  input  logic                  pop
);

  cfg_t  cfg_q;
  item_t head;
  logic  head_empty;
  logic  head_pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_KEY_0:      cfg_q.key[1:0]  <= cfg_wdata_i;
        REG_KEY_1:      cfg_q.key[3:2]  <= cfg_wdata_i;
        REG_KEY_2:      cfg_q.key[5:4]  <= cfg_wdata_i;
        REG_KEY_3:      cfg_q.key[7:6]  <= cfg_wdata_i;
        REG_NONCE_LOW:  cfg_q.nonce[1:0] <= cfg_wdata_i;
        REG_NONCE_HIGH: cfg_q.nonce[2]   <= cfg_wdata_i[31:0];
        REG_INIT_CTR:   cfg_q.init_ctr   <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  cc20_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .data_in_i       (data_in_i),
    .message_start_i (message_start_i),
    .push_i          (push),
    .full_o          (full),
    .head_pop_i      (head_pop),
    .head_o          (head),
    .head_empty_o    (head_empty)
  );

  cc20_core #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_i       (head),
    .head_empty_i (head_empty),
    .head_pop_o   (head_pop),
    .out_pop_i    (pop),
    .out_empty_o  (empty),
    .data_out_o   (data_out_o)
  );

endmodule
